/* rtl/core/b64se_pkg.sv */
// Shared types, register codes and the sextet alphabet for the Base64 stream encoder.
`default_nettype none

package b64se_pkg;

  localparam int unsigned BurstMax = 5;
  localparam int unsigned BurstCntW = 3;
  localparam int unsigned LineCntW = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [7:0] CHAR_PAD = 8'd61;
  localparam logic [7:0] CHAR_NL = 8'd10;
  localparam logic [LineCntW-1:0] LINE_COUNT_MAX = {LineCntW{1'b1}};

  localparam logic [CfgDataW-1:0] LINE_LIMIT_RST = 10'd76;
  localparam logic [7:0] CHAR62_RST = 8'd43;
  localparam logic [7:0] CHAR63_RST = 8'd47;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BREAK_ENABLE  = 3'd0,
    REG_LINE_LIMIT    = 3'd1,
    REG_PAD_ENABLE    = 3'd2,
    REG_CHAR_FOR_62   = 3'd3,
    REG_CHAR_FOR_63   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic       break_enable;
    logic [9:0] line_limit;
    logic       pad_enable;
    logic [7:0] char_for_62;
    logic [7:0] char_for_63;
  } cfg_t;

  typedef struct packed {
    logic [BurstMax-1:0][7:0] chars;
    logic [BurstCntW-1:0]     cnt;
  } burst_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] s, input logic [7:0] c62,
                                             input logic [7:0] c63);
    logic [7:0] ch;
    if (s < 6'd26) begin
      ch = 8'd65 + {2'b00, s};
    end else if (s < 6'd52) begin
      ch = 8'd97 + ({2'b00, s} - 8'd26);
    end else if (s < 6'd62) begin
      ch = 8'd48 + ({2'b00, s} - 8'd52);
    end else if (s == 6'd62) begin
      ch = c62;
    end else begin
      ch = c63;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/b64se_cfg.sv */
// Configuration register file of the Base64 stream encoder.
`default_nettype none

module b64se_cfg
  import b64se_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_BREAK_ENABLE:  cfg_nxt.break_enable = cfg_data[0];
        REG_LINE_LIMIT:    cfg_nxt.line_limit = cfg_data;
        REG_PAD_ENABLE:    cfg_nxt.pad_enable = cfg_data[0];
        REG_CHAR_FOR_62:   cfg_nxt.char_for_62 = cfg_data[7:0];
        REG_CHAR_FOR_63:   cfg_nxt.char_for_63 = cfg_data[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.break_enable <= 1'b0;
      cfg_r.line_limit <= LINE_LIMIT_RST;
      cfg_r.pad_enable <= 1'b1;
      cfg_r.char_for_62 <= CHAR62_RST;
      cfg_r.char_for_63 <= CHAR63_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/b64se_group.sv */
// Byte grouping, line counting and character burst build of the Base64 stream encoder.
`default_nettype none

module b64se_group
  import b64se_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  in_item_t item,
  input  logic     advance,
  output burst_t   burst
);

  logic [15:0]         held_r;
  logic [15:0]         held_nxt;
  logic [1:0]          phase_r;
  logic [1:0]          phase_nxt;
  logic [LineCntW-1:0] line_r;
  logic [LineCntW-1:0] line_nxt;

  logic [7:0]          a;
  logic [7:0]          b;
  logic [7:0]          d;
  logic [5:0]          sx0;
  logic [5:0]          sx1;
  logic [5:0]          sx2;
  logic [5:0]          sx3;
  logic [7:0]          ch0;
  logic [7:0]          ch1;
  logic [7:0]          ch2;
  logic [7:0]          ch3;
  logic [LineCntW:0]   line_sum;
  logic [LineCntW-1:0] line_sat;
  logic                break_now;

  assign a = held_r[15:8];
  assign b = held_r[7:0];
  assign d = item.data_byte;

  always_comb begin
    case (phase_r)
      2'd0: begin
        sx0 = d[7:2];
        sx1 = {d[1:0], 4'b0000};
        sx2 = 6'd0;
        sx3 = 6'd0;
      end
      2'd1: begin
        sx0 = a[7:2];
        sx1 = {a[1:0], d[7:4]};
        sx2 = {d[3:0], 2'b00};
        sx3 = 6'd0;
      end
      default: begin
        sx0 = a[7:2];
        sx1 = {a[1:0], b[7:4]};
        sx2 = {b[3:0], d[7:6]};
        sx3 = d[5:0];
      end
    endcase
  end

  assign ch0 = sextet_char(sx0, cfg.char_for_62, cfg.char_for_63);
  assign ch1 = sextet_char(sx1, cfg.char_for_62, cfg.char_for_63);
  assign ch2 = sextet_char(sx2, cfg.char_for_62, cfg.char_for_63);
  assign ch3 = sextet_char(sx3, cfg.char_for_62, cfg.char_for_63);

  assign line_sum = {1'b0, line_r} + (LineCntW + 1)'(4);
  assign line_sat = line_sum[LineCntW] ? LINE_COUNT_MAX : line_sum[LineCntW-1:0];
  assign break_now = cfg.break_enable && (cfg.line_limit != 10'd0)
                     && (line_sat >= {1'b0, cfg.line_limit});

  always_comb begin
    held_nxt = held_r;
    phase_nxt = phase_r;
    line_nxt = line_r;
    burst.chars = '0;
    burst.cnt = '0;
    case (phase_r)
      2'd0: begin
        if (!item.final_byte) begin
          held_nxt = {d, 8'h00};
          phase_nxt = 2'd1;
        end else begin
          burst.chars = {CHAR_PAD, CHAR_PAD, CHAR_PAD, ch1, ch0};
          burst.cnt = cfg.pad_enable ? BurstCntW'(4) : BurstCntW'(2);
          held_nxt = '0;
          phase_nxt = 2'd0;
          line_nxt = '0;
        end
      end
      2'd1: begin
        if (!item.final_byte) begin
          held_nxt = {a, d};
          phase_nxt = 2'd2;
        end else begin
          burst.chars = {CHAR_PAD, CHAR_PAD, ch2, ch1, ch0};
          burst.cnt = cfg.pad_enable ? BurstCntW'(4) : BurstCntW'(3);
          held_nxt = '0;
          phase_nxt = 2'd0;
          line_nxt = '0;
        end
      end
      default: begin
        burst.chars = {CHAR_NL, ch3, ch2, ch1, ch0};
        held_nxt = '0;
        phase_nxt = 2'd0;
        if (item.final_byte) begin
          burst.cnt = BurstCntW'(4);
          line_nxt = '0;
        end else if (break_now) begin
          burst.cnt = BurstCntW'(5);
          line_nxt = '0;
        end else begin
          burst.cnt = BurstCntW'(4);
          line_nxt = line_sat;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      phase_r <= 2'd0;
      line_r <= '0;
    end else if (advance) begin
      held_r <= held_nxt;
      phase_r <= phase_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/b64se_serial.sv */
// Character burst register that hands out one character per beat.
`default_nettype none

module b64se_serial
  import b64se_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  burst_t    burst_in,
  input  logic      out_stall,
  output logic      free,
  output logic      out_valid,
  output out_item_t out_data
);

  logic [BurstMax-1:0][7:0] chars_r;
  logic [BurstMax-1:0][7:0] chars_nxt;
  logic [BurstCntW-1:0]     cnt_r;
  logic [BurstCntW-1:0]     cnt_nxt;

  assign out_valid = (cnt_r != '0);
  assign free = (cnt_r == '0) || ((cnt_r == BurstCntW'(1)) && !out_stall);
  assign out_data.text_char = chars_r[0];
  assign out_data.run_end = (cnt_r == BurstCntW'(1));

  always_comb begin
    chars_nxt = chars_r;
    cnt_nxt = cnt_r;
    if (load) begin
      chars_nxt = burst_in.chars;
      cnt_nxt = burst_in.cnt;
    end else if (out_valid && !out_stall) begin
      chars_nxt = chars_r >> 8;
      cnt_nxt = cnt_r - BurstCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/base64_stream_encoder.sv */
// Top level of the Base64 stream encoder: input register, grouping logic, character output.
//
//   port group   direction  handshake           beat
//   in_*         in         in_valid/in_stall   one message byte and its final flag
//   out_*        out        out_valid/out_stall one character and its run-end flag
//   cfg_*        in         cfg_valid/cfg_ready one register index and write data
//
// A byte waits in the input register; a group's last byte loads the character register.
// A completed group gives 2 to 5 characters, one per beat; other bytes give none.
// A byte is taken every cycle while the character register is empty or emptying.
// rst_n is synchronous: it clears the group state, empties both registers and
// restores register defaults. Stalls on out_* hold the character and back up to in_stall.
`default_nettype none

module base64_stream_encoder
  import b64se_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t     cfg;
  burst_t   burst;
  in_item_t item_r;
  in_item_t item_nxt;
  logic     item_valid_r;
  logic     item_valid_nxt;
  logic     in_take;
  logic     advance;
  logic     ser_free;
  logic     load;

  assign cfg_ready = 1'b1;

  b64se_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  b64se_group u_group (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (item_r),
    .advance (advance),
    .burst   (burst)
  );

  b64se_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .burst_in  (burst),
    .out_stall (out_stall),
    .free      (ser_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign advance = item_valid_r && ((burst.cnt == '0) || ser_free);
  assign load = advance && (burst.cnt != '0);
  assign in_stall = item_valid_r && !advance;
  assign in_take = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    item_nxt = item_r;
    if (in_take) begin
      item_valid_nxt = 1'b1;
      item_nxt = in_data;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  a_load_into_free : assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ser_free)
    else $error("burst loaded over pending characters");

  a_burst_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r |-> (burst.cnt <= BurstCntW'(BurstMax)))
    else $error("burst count out of range");

  a_stall_held : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid_r && (burst.cnt != '0) && out_valid)
    else $error("input stalled without pending characters");

  a_load_valid : assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("loaded burst not presented");

endmodule

`default_nettype wire
